### hw/rtl/ifp_pkg.sv
package ifp_pkg;

   localparam int BYTE_WIDTH = 8;
   localparam int WORD_WIDTH = 16;
   localparam int COUNT_WIDTH = 32;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH = 16;
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_WIDTH = 1;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HEADER_BYTE = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_WRAP_THRESHOLD = 2'd1;

   localparam logic [BYTE_WIDTH-1:0] HEADER_BYTE_RESET = 8'h5A;
   localparam logic [WORD_WIDTH-1:0] WRAP_THRESHOLD_RESET = 16'd30000;

   localparam logic signed [WORD_WIDTH:0] TURN_SCALE = 17'sd36000;
   localparam logic signed [WORD_WIDTH-1:0] TURNS_MAX = 16'sh7FFF;
   localparam logic signed [WORD_WIDTH-1:0] TURNS_MIN = 16'sh8000;

   typedef struct packed {
      logic [WORD_WIDTH-1:0] gyro_x;
      logic [WORD_WIDTH-1:0] gyro_y;
      logic [WORD_WIDTH-1:0] gyro_z;
      logic [WORD_WIDTH-1:0] yaw_angle;
      logic [WORD_WIDTH-1:0] roll_angle;
      logic [WORD_WIDTH-1:0] pitch_angle;
      logic [BYTE_WIDTH-1:0] device_status;
   } frame_fields_type;

endpackage

### hw/rtl/ifp_front.sv
module ifp_front #(
   parameter int FRAME_LENGTH = 18
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [7:0]                     req_data_byte,
   input  logic [7:0]                     header_byte,
   input  logic                           queue_full,
   output logic                           push,
   output ifp_pkg::frame_fields_type      push_fields
);
   import ifp_pkg::*;

   localparam int FILL_WIDTH = $clog2(FRAME_LENGTH + 1);
   localparam logic [FILL_WIDTH-1:0] FILL_FULL = FILL_WIDTH'(FRAME_LENGTH);
   localparam logic [FILL_WIDTH-1:0] FILL_LAST = FILL_WIDTH'(FRAME_LENGTH - 1);

   logic [BYTE_WIDTH-1:0] win_ff [FRAME_LENGTH];
   logic [BYTE_WIDTH-1:0] win_in [FRAME_LENGTH];
   logic [FILL_WIDTH-1:0] fill_ff, fill_in;
   logic [BYTE_WIDTH-1:0] sum_ff, sum_in;
   logic [BYTE_WIDTH-1:0] sum_head;
   logic                  accept;
   logic                  frame_ok;

   assign req_stall = queue_full;
   assign accept    = req_valid && !req_stall;

   // sum of the bytes that precede the new byte once the oldest one drops out
   assign sum_head = sum_ff - win_ff[0];
   assign frame_ok = (fill_ff >= FILL_LAST) && (win_ff[1] == header_byte) &&
                     (win_ff[2] == header_byte) && (sum_head == req_data_byte);

   assign push = accept && frame_ok;

   // new window byte i is old byte i+1
   assign push_fields.gyro_x        = {win_ff[5], win_ff[6]};
   assign push_fields.gyro_y        = {win_ff[7], win_ff[8]};
   assign push_fields.gyro_z        = {win_ff[9], win_ff[10]};
   assign push_fields.yaw_angle     = {win_ff[11], win_ff[12]};
   assign push_fields.roll_angle    = {win_ff[13], win_ff[14]};
   assign push_fields.pitch_angle   = {win_ff[15], win_ff[16]};
   assign push_fields.device_status = win_ff[17];

   always_comb begin
      win_in  = win_ff;
      fill_in = fill_ff;
      sum_in  = sum_ff;
      if (accept) begin
         if (frame_ok) begin
            for (int i = 0; i < FRAME_LENGTH; i++) begin
               win_in[i] = '0;
            end
            fill_in = '0;
            sum_in  = '0;
         end else begin
            for (int i = 0; i < FRAME_LENGTH - 1; i++) begin
               win_in[i] = win_ff[i+1];
            end
            win_in[FRAME_LENGTH-1] = req_data_byte;
            fill_in = (fill_ff == FILL_FULL) ? FILL_FULL : fill_ff + 1'b1;
            sum_in  = sum_head + req_data_byte;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < FRAME_LENGTH; i++) begin
            win_ff[i] <= '0;
         end
         fill_ff <= '0;
         sum_ff  <= '0;
      end else begin
         win_ff  <= win_in;
         fill_ff <= fill_in;
         sum_ff  <= sum_in;
      end
   end

endmodule

### hw/rtl/ifp_queue.sv
module ifp_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  ifp_pkg::frame_fields_type push_fields,
   output logic                      full,
   output logic                      not_empty,
   input  logic                      pop,
   output ifp_pkg::frame_fields_type pop_fields
);
   import ifp_pkg::*;

   localparam int LEVEL_WIDTH = $clog2(QUEUE_DEPTH + 1);

   frame_fields_type            entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_WIDTH-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_WIDTH-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [LEVEL_WIDTH-1:0]      level_ff, level_in;

   assign full       = (level_ff == LEVEL_WIDTH'(QUEUE_DEPTH));
   assign not_empty  = (level_ff != '0);
   assign pop_fields = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in  = level_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         level_in = level_ff + 1'b1;
      end else if (pop && !push) begin
         level_in = level_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_fields;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

endmodule

### hw/rtl/ifp_back.sv
module ifp_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [15:0]               wrap_threshold,
   input  logic                      queue_not_empty,
   output logic                      pop,
   input  ifp_pkg::frame_fields_type pop_fields,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [15:0]        rsp_gyro_x,
   output logic signed [15:0]        rsp_gyro_y,
   output logic signed [15:0]        rsp_gyro_z,
   output logic [15:0]               rsp_yaw_angle,
   output logic signed [15:0]        rsp_roll_angle,
   output logic signed [15:0]        rsp_pitch_angle,
   output logic [7:0]                rsp_device_status,
   output logic signed [15:0]        rsp_turns,
   output logic signed [31:0]        rsp_total_yaw,
   output logic [31:0]               rsp_frames_seen
);
   import ifp_pkg::*;

   logic                          prev_yaw_unused;
   logic [WORD_WIDTH-1:0]         prev_yaw_ff;
   logic signed [WORD_WIDTH-1:0]  turns_ff, turns_in;
   logic [COUNT_WIDTH-1:0]        frames_ff;

   logic                          s1_valid_ff;
   frame_fields_type              s1_fields_ff;
   logic signed [WORD_WIDTH-1:0]  s1_turns_ff;
   logic [COUNT_WIDTH-1:0]        s1_frames_ff;

   logic                          out_valid_ff;
   frame_fields_type              out_fields_ff;
   logic signed [WORD_WIDTH-1:0]  out_turns_ff;
   logic signed [COUNT_WIDTH-1:0] out_total_ff, out_total_in;
   logic [COUNT_WIDTH-1:0]        out_frames_ff;

   logic                          out_ready;
   logic                          s1_ready;
   logic signed [WORD_WIDTH:0]    yaw_diff;
   logic signed [WORD_WIDTH:0]    thr_pos;
   logic signed [WORD_WIDTH:0]    thr_neg;
   logic signed [WORD_WIDTH+16:0] turn_product;

   assign prev_yaw_unused = 1'b0;

   assign out_ready = !out_valid_ff || !rsp_stall;
   assign s1_ready  = !s1_valid_ff || out_ready;
   assign pop       = queue_not_empty && s1_ready;

   // yaw falling past the threshold is one more turn, rising past it one less
   assign yaw_diff = $signed({1'b0, pop_fields.yaw_angle}) - $signed({1'b0, prev_yaw_ff});
   assign thr_pos  = $signed({1'b0, wrap_threshold});
   assign thr_neg  = -thr_pos;

   always_comb begin
      turns_in = turns_ff;
      if (yaw_diff < thr_neg && turns_ff != TURNS_MAX) begin
         turns_in = turns_ff + 16'sd1;
      end else if (yaw_diff > thr_pos && turns_ff != TURNS_MIN) begin
         turns_in = turns_ff - 16'sd1;
      end
   end

   assign turn_product = s1_turns_ff * TURN_SCALE;
   assign out_total_in = turn_product[COUNT_WIDTH-1:0] +
                         $signed({16'b0, s1_fields_ff.yaw_angle});

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_yaw_ff <= '0;
         turns_ff    <= '0;
         frames_ff   <= '0;
      end else if (pop) begin
         prev_yaw_ff <= pop_fields.yaw_angle | {WORD_WIDTH{prev_yaw_unused}};
         turns_ff    <= turns_in;
         frames_ff   <= frames_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) begin
            s1_valid_ff <= pop;
         end
         if (out_ready) begin
            out_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         s1_fields_ff <= pop_fields;
         s1_turns_ff  <= turns_in;
         s1_frames_ff <= frames_ff + 1'b1;
      end
      if (out_ready && s1_valid_ff) begin
         out_fields_ff <= s1_fields_ff;
         out_turns_ff  <= s1_turns_ff;
         out_total_ff  <= out_total_in;
         out_frames_ff <= s1_frames_ff;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_gyro_x        = $signed(out_fields_ff.gyro_x);
   assign rsp_gyro_y        = $signed(out_fields_ff.gyro_y);
   assign rsp_gyro_z        = $signed(out_fields_ff.gyro_z);
   assign rsp_yaw_angle     = out_fields_ff.yaw_angle;
   assign rsp_roll_angle    = $signed(out_fields_ff.roll_angle);
   assign rsp_pitch_angle   = $signed(out_fields_ff.pitch_angle);
   assign rsp_device_status = out_fields_ff.device_status;
   assign rsp_turns         = out_turns_ff;
   assign rsp_total_yaw     = out_total_ff;
   assign rsp_frames_seen   = out_frames_ff;

endmodule

### hw/rtl/imu_frame_parser_yaw_unwrap.sv
// Byte-stream frame parser for an IMU link. Takes one byte per cycle unless
// req_stall is high, and checks a sliding window of FRAME_LENGTH bytes; a
// frame with two header bytes equal to header_byte and a last byte equal to
// the 8-bit sum of the others yields one item with the big-endian sensor
// fields, the saturating turn count, the unwrapped yaw and the frame count,
// and empties the window. A running window sum makes the check one add and
// compare per byte, so the input takes one byte every cycle while not stalled.
// The frame is written into a two-entry frame queue between the parser and
// the unwrap pipeline, then passes the unwrap stage and the multiply for total
// yaw into the output register; req_stall rises only while that queue is full.
module imu_frame_parser_yaw_unwrap #(
   parameter int FRAME_LENGTH = 18
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [7:0]          req_data_byte,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [15:0]  rsp_gyro_x,
   output logic signed [15:0]  rsp_gyro_y,
   output logic signed [15:0]  rsp_gyro_z,
   output logic [15:0]         rsp_yaw_angle,
   output logic signed [15:0]  rsp_roll_angle,
   output logic signed [15:0]  rsp_pitch_angle,
   output logic [7:0]          rsp_device_status,
   output logic signed [15:0]  rsp_turns,
   output logic signed [31:0]  rsp_total_yaw,
   output logic [31:0]         rsp_frames_seen,
   input  logic                csr_we,
   input  logic [1:0]          csr_index,
   input  logic [15:0]         csr_wdata
);
   import ifp_pkg::*;

   logic [BYTE_WIDTH-1:0] header_ff;
   logic [WORD_WIDTH-1:0] threshold_ff;
   logic                  push;
   frame_fields_type      push_fields;
   logic                  queue_full;
   logic                  queue_not_empty;
   logic                  pop;
   frame_fields_type      pop_fields;

   always_ff @(posedge clock) begin
      if (reset) begin
         header_ff    <= HEADER_BYTE_RESET;
         threshold_ff <= WRAP_THRESHOLD_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_HEADER_BYTE: begin
               header_ff <= csr_wdata[BYTE_WIDTH-1:0];
            end
            CSR_WRAP_THRESHOLD: begin
               threshold_ff <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   ifp_front #(
      .FRAME_LENGTH(FRAME_LENGTH)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .header_byte   (header_ff),
      .queue_full    (queue_full),
      .push          (push),
      .push_fields   (push_fields)
   );

   ifp_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .push_fields (push_fields),
      .full        (queue_full),
      .not_empty   (queue_not_empty),
      .pop         (pop),
      .pop_fields  (pop_fields)
   );

   ifp_back u_back (
      .clock             (clock),
      .reset             (reset),
      .wrap_threshold    (threshold_ff),
      .queue_not_empty   (queue_not_empty),
      .pop               (pop),
      .pop_fields        (pop_fields),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_gyro_x        (rsp_gyro_x),
      .rsp_gyro_y        (rsp_gyro_y),
      .rsp_gyro_z        (rsp_gyro_z),
      .rsp_yaw_angle     (rsp_yaw_angle),
      .rsp_roll_angle    (rsp_roll_angle),
      .rsp_pitch_angle   (rsp_pitch_angle),
      .rsp_device_status (rsp_device_status),
      .rsp_turns         (rsp_turns),
      .rsp_total_yaw     (rsp_total_yaw),
      .rsp_frames_seen   (rsp_frames_seen)
   );

endmodule
